>>> hw/rtl/prl_pkg.sv
// ----------------------------------------------------------------------------
// Per-source packet rate limiter package
// Shared widths, defaults and transfer payload types.
// ----------------------------------------------------------------------------
package prl_pkg;

  localparam int FLOW_ENTRIES_DEF = 16;
  localparam int ADDR_W           = 32;
  localparam int SECOND_W         = 32;
  localparam int LIMIT_W          = 16;
  // Count saturates at limit + 1, so one bit wider than the limit.
  localparam int COUNT_W          = LIMIT_W + 1;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

  typedef struct packed {
    logic [ADDR_W-1:0]   source_address;
    logic [SECOND_W-1:0] current_second;
  } in_item_t;

  typedef struct packed {
    logic allowed;
    logic first_alert;
    logic table_full;
  } out_item_t;

endpackage

>>> hw/rtl/prl_flow_table.sv
// ----------------------------------------------------------------------------
// Flow table
// Fully associative flow entries; lookup and decision are combinational, the update is registered.
// ----------------------------------------------------------------------------
module prl_flow_table #(
  parameter int FLOW_ENTRIES = prl_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         upd_en,
  input  prl_pkg::in_item_t            item,
  input  logic [prl_pkg::LIMIT_W-1:0]  packet_limit,
  output prl_pkg::out_item_t           decision
);
  import prl_pkg::*;

  logic                entry_valid   [FLOW_ENTRIES];
  logic [ADDR_W-1:0]   entry_address [FLOW_ENTRIES];
  logic [SECOND_W-1:0] entry_window  [FLOW_ENTRIES];
  logic [COUNT_W-1:0]  entry_count   [FLOW_ENTRIES];
  logic                entry_alerted [FLOW_ENTRIES];

  logic [FLOW_ENTRIES-1:0] hit_vec;
  logic [FLOW_ENTRIES-1:0] free_vec;
  logic [FLOW_ENTRIES-1:0] first_free;
  logic [FLOW_ENTRIES-1:0] sel_vec;
  logic                    hit_any;
  logic                    full;
  logic [SECOND_W-1:0]     sel_window;
  logic [COUNT_W-1:0]      sel_count;
  logic                    sel_alerted;
  logic                    fresh;
  logic [COUNT_W-1:0]      count_base;
  logic                    alerted_base;
  logic [COUNT_W-1:0]      count_next;
  logic                    deny;
  logic [COUNT_W-1:0]      limit_ext;

  // Compare every entry in parallel.
  always_comb begin
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      hit_vec[i]  = entry_valid[i] && (entry_address[i] == item.source_address);
      free_vec[i] = !entry_valid[i] || (entry_window[i] != item.current_second);
    end
  end

  // Lowest set bit of the free vector.
  assign first_free = free_vec & (~free_vec + FLOW_ENTRIES'(1));
  assign hit_any    = |hit_vec;
  assign sel_vec    = hit_any ? hit_vec : first_free;
  assign full       = !hit_any && !(|free_vec);

  // One-hot select of the chosen entry.
  always_comb begin
    sel_window  = '0;
    sel_count   = '0;
    sel_alerted = 1'b0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      if (sel_vec[i]) begin
        sel_window  = sel_window | entry_window[i];
        sel_count   = sel_count | entry_count[i];
        sel_alerted = sel_alerted | entry_alerted[i];
      end
    end
  end

  // A claimed or stale entry starts a new window.
  assign fresh        = !hit_any || (sel_window != item.current_second);
  assign count_base   = fresh ? '0 : sel_count;
  assign alerted_base = fresh ? 1'b0 : sel_alerted;
  assign limit_ext    = {1'b0, packet_limit};
  assign count_next   = (count_base <= limit_ext) ? count_base + COUNT_W'(1) : count_base;
  assign deny         = count_next > limit_ext;

  always_comb begin
    if (full) begin
      decision.allowed     = 1'b1;
      decision.first_alert = 1'b0;
      decision.table_full  = 1'b1;
    end else begin
      decision.allowed     = !deny;
      decision.first_alert = deny && !alerted_base;
      decision.table_full  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        entry_valid[i] <= 1'b0;
      end
    end else if (upd_en && !full) begin
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        if (sel_vec[i]) begin
          entry_valid[i] <= 1'b1;
        end
      end
    end
  end

  // Entry payload holds no reset; it is only read behind a valid bit.
  always_ff @(posedge clk) begin
    if (upd_en && !full) begin
      for (int i = 0; i < FLOW_ENTRIES; i++) begin
        if (sel_vec[i]) begin
          entry_address[i] <= item.source_address;
          entry_window[i]  <= item.current_second;
          entry_count[i]   <= count_next;
          entry_alerted[i] <= alerted_base | deny;
        end
      end
    end
  end

endmodule

>>> hw/rtl/per_source_packet_rate_limiter_core.sv
// ----------------------------------------------------------------------------
// Per-source packet rate limiter core
// Fixed-window rate decision per packet, keyed by sender address.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   in        input      in_valid / in_stall  in_data  (source_address, current_second)
//   out       output     out_valid / out_stall out_data (allowed, first_alert, table_full)
//   cfg       input      cfg_valid / cfg_ready cfg_data (packet_limit)
//
// One packet per cycle sustained while out is not stalled. A packet passes
// through the input register and then the result register, around the
// combinational flow table lookup and decision.
// Synchronous reset clears all flow entries' valid bits and the pipeline;
// packet_limit returns to 100. No clearing pass is needed.
// A stall on out holds the result register and the input register, and
// in_stall rises only while the input register cannot advance.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter_core #(
  parameter int FLOW_ENTRIES = prl_pkg::FLOW_ENTRIES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  prl_pkg::in_item_t            in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output prl_pkg::out_item_t           out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [prl_pkg::LIMIT_W-1:0]  cfg_data
);
  import prl_pkg::*;

  logic               hold_valid;
  in_item_t           hold_item;
  logic [LIMIT_W-1:0] packet_limit;
  out_item_t          decision;
  logic               advance;

  // Configuration is always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_limit <= LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      packet_limit <= cfg_data;
    end
  end

  // Advance the held packet when the result register is free or draining.
  assign advance  = hold_valid && (!out_valid || !out_stall);
  assign in_stall = hold_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (!in_stall) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_item <= in_data;
    end
  end

  // Lookup, decide and update the table in the cycle the packet advances.
  prl_flow_table #(
    .FLOW_ENTRIES(FLOW_ENTRIES)
  ) u_flow_table (
    .clk          (clk),
    .rst          (rst),
    .upd_en       (advance),
    .item         (hold_item),
    .packet_limit (packet_limit),
    .decision     (decision)
  );

  // Result register: load on advance, drop valid once the transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= decision;
    end
  end

endmodule

>>> dv/per_source_packet_rate_limiter_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Per-source packet rate limiter core testbench
// Drives packets with random sources and seconds under several packet limits.
// A scoreboard class keeps its own flow table, predicts each decision and
// checks the decisions that the core returns, in order.
// ----------------------------------------------------------------------------
module per_source_packet_rate_limiter_core_test;
  import prl_pkg::*;

  // Flow table mirror and decision checker.
  class rate_scoreboard;
    logic [LIMIT_W-1:0]  limit;
    bit                  live    [FLOW_ENTRIES_DEF];
    logic [ADDR_W-1:0]   owner   [FLOW_ENTRIES_DEF];
    logic [SECOND_W-1:0] window  [FLOW_ENTRIES_DEF];
    logic [COUNT_W-1:0]  count   [FLOW_ENTRIES_DEF];
    bit                  alerted [FLOW_ENTRIES_DEF];
    out_item_t           decision_q[$];
    int unsigned         decisions_seen;
    int unsigned         mismatches;

    function new();
      limit = LIMIT_RESET;
      foreach (live[i]) live[i] = 1'b0;
      decisions_seen = 0;
      mismatches = 0;
    endfunction

    function void set_limit(logic [LIMIT_W-1:0] value);
      limit = value;
    endfunction

    function void flag(string what, logic [2:0] want, logic [2:0] got);
      if (mismatches < 10)
        $display("[%0t] mismatch: %s expected %b got %b", $time, what, want, got);
      mismatches++;
    endfunction

    // Look up or claim an entry, update it and queue the decision.
    function void note_packet(in_item_t pkt);
      int        slot;
      out_item_t d;
      slot = -1;
      for (int i = 0; i < FLOW_ENTRIES_DEF; i++) begin
        if (live[i] && owner[i] == pkt.source_address) begin
          slot = i;
          break;
        end
      end
      if (slot < 0) begin
        for (int i = 0; i < FLOW_ENTRIES_DEF; i++) begin
          if (!live[i] || window[i] != pkt.current_second) begin
            slot = i;
            break;
          end
        end
        if (slot < 0) begin
          // Every entry busy this second: pass untracked, no state change.
          d.allowed     = 1'b1;
          d.first_alert = 1'b0;
          d.table_full  = 1'b1;
          decision_q.push_back(d);
          return;
        end
        live[slot]    = 1'b1;
        owner[slot]   = pkt.source_address;
        window[slot]  = pkt.current_second;
        count[slot]   = '0;
        alerted[slot] = 1'b0;
      end
      if (window[slot] != pkt.current_second) begin
        window[slot]  = pkt.current_second;
        count[slot]   = '0;
        alerted[slot] = 1'b0;
      end
      if (count[slot] <= {1'b0, limit}) count[slot] = count[slot] + 1'b1;
      d.table_full = 1'b0;
      if (count[slot] > {1'b0, limit}) begin
        d.allowed     = 1'b0;
        d.first_alert = !alerted[slot];
        alerted[slot] = 1'b1;
      end else begin
        d.allowed     = 1'b1;
        d.first_alert = 1'b0;
      end
      decision_q.push_back(d);
    endfunction

    function void check_decision(out_item_t got);
      out_item_t want;
      decisions_seen++;
      if (decision_q.size() == 0) begin
        flag("decision with nothing pending", 3'bxxx, got);
        return;
      end
      want = decision_q.pop_front();
      if (got.allowed !== want.allowed)
        flag("allowed", {2'b00, want.allowed}, {2'b00, got.allowed});
      if (got.first_alert !== want.first_alert)
        flag("first_alert", {2'b00, want.first_alert}, {2'b00, got.first_alert});
      if (got.table_full !== want.table_full)
        flag("table_full", {2'b00, want.table_full}, {2'b00, got.table_full});
    endfunction

    // Anything still queued at the end never came back.
    function void close_out();
      while (decision_q.size() != 0) flag("missing decision", decision_q.pop_front(), 3'bzzz);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  in_item_t           in_data;
  logic               out_valid;
  logic               out_stall;
  out_item_t          out_data;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data;

  rate_scoreboard sb = new();

  bit          idle_on = 1'b1;   // random gaps on both sides
  bit          long_hold_req;    // ask the receiver for one long hold-off
  int unsigned packets_sent;

  per_source_packet_rate_limiter_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Observe every transfer at the edge where it happens. Values read here are
  // the ones from before the edge, so predict and check stay race free.
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_data);
      if (in_valid && !in_stall) sb.note_packet(in_data);
      if (out_valid && !out_stall) sb.check_decision(out_data);
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request so the
  // pipeline fills and backs up into in_stall.
  initial begin : result_sink
    int unsigned held;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < 60; held++) @(posedge clk);
        long_hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Hard stop in case the core hangs.
  initial begin : watchdog
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic in_item_t make_packet(logic [ADDR_W-1:0] addr, logic [SECOND_W-1:0] sec);
    in_item_t pkt;
    pkt.source_address = addr;
    pkt.current_second = sec;
    return pkt;
  endfunction

  // Offer one packet and hold it until the transfer; maybe idle afterwards.
  task automatic send_packet(in_item_t pkt);
    in_data  <= pkt;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    packets_sent++;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stop offering and wait until every decision has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.decisions_seen < packets_sent) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One random phase: a pool of recurring sources with a slowly advancing
  // second, heavy hitters near the front of the pool, and some noise.
  task automatic run_flows(int unsigned n_items, logic [LIMIT_W-1:0] value,
                           int unsigned pool_size, int unsigned adv_odds,
                           bit quiet, bit hold);
    logic [ADDR_W-1:0]   pool[24];
    logic [SECOND_W-1:0] now;
    logic [ADDR_W-1:0]   addr;
    logic [SECOND_W-1:0] sec;
    int unsigned         pick;
    settle();
    idle_on = !quiet;
    write_limit(value);
    foreach (pool[i]) pool[i] = $urandom;
    if ($urandom_range(0, 1)) pool[0] = '0;
    if ($urandom_range(0, 1)) pool[1] = '1;
    now = $urandom;
    for (int unsigned n = 0; n < n_items; n++) begin
      if (hold && n == 20) long_hold_req = 1'b1;
      if ($urandom_range(1, adv_odds) == 1) now = now + 1'b1;
      if ($urandom_range(0, 39) == 0) now = $urandom;
      pick = $urandom_range(0, 1) ? $urandom_range(0, (pool_size < 3) ? pool_size - 1 : 2)
                                  : $urandom_range(0, pool_size - 1);
      addr = pool[pick];
      sec  = now;
      case ($urandom_range(0, 19))
        0:       addr = $urandom;          // stray source
        1:       sec  = $urandom;          // stray second
        2:       sec  = now - 1'b1;        // late packet from an older window
        default: ;
      endcase
      send_packet(make_packet(addr, sec));
    end
  endtask

  initial begin : stimulus
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    packets_sent  = 0;
    long_hold_req = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset limit: a couple of packets pass.
    send_packet(make_packet(32'h0000_0001, 32'd0));
    send_packet(make_packet(32'h0000_0001, 32'd0));

    // Zero limit: deny everything, alert once per window.
    settle();
    write_limit('0);
    send_packet(make_packet(32'h0000_0000, 32'h0000_0000));
    send_packet(make_packet(32'h0000_0000, 32'h0000_0000));
    send_packet(make_packet(32'h0000_0000, 32'h0000_0001));
    send_packet(make_packet(32'hFFFF_FFFF, 32'hFFFF_FFFF));

    // Limit of one: pass, first denial, then saturated denial.
    settle();
    write_limit(LIMIT_W'(1));
    send_packet(make_packet(32'h0A00_0001, 32'd5));
    send_packet(make_packet(32'h0A00_0001, 32'd5));
    send_packet(make_packet(32'h0A00_0001, 32'd5));

    // Max limit: fill the table in one second, overflow it, then claim a
    // stale entry in the next second.
    settle();
    write_limit('1);
    for (int i = 0; i < FLOW_ENTRIES_DEF; i++)
      send_packet(make_packet(32'hC0A8_0000 + i, 32'd7));
    send_packet(make_packet(32'hC0A8_00FF, 32'd7));
    send_packet(make_packet(32'hC0A8_0100, 32'd8));

    // Random phases.
    run_flows(220, LIMIT_W'(3), 6, 12, 1'b0, 1'b0);
    run_flows(220, '0, 20, 10, 1'b0, 1'b0);
    run_flows(220, '1, 24, 60, 1'b0, 1'b0);
    run_flows(220, LIMIT_W'(1), 4, 8, 1'b0, 1'b1);
    run_flows(220, LIMIT_W'($urandom_range(2, 12)), 12, 15, 1'b0, 1'b0);
    run_flows(300, LIMIT_RESET, 2, 1000, 1'b0, 1'b0);
    run_flows(300, LIMIT_W'(5), 10, 12, 1'b1, 1'b0);

    // Drain, give the pipeline time to show any stray decision, then judge.
    settle();
    repeat (8) @(posedge clk);
    sb.close_out();
    if (sb.mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/prl_pkg.sv
hw/rtl/prl_flow_table.sv
hw/rtl/per_source_packet_rate_limiter_core.sv
dv/per_source_packet_rate_limiter_core_test.sv
